>>> sv/iau_pkg.sv
// Shared types, widths and codes for the interval arithmetic unit.
// Used by every pipeline stage, the top level and the checker.
`default_nettype none

package iau_pkg;

  // bound format: signed fixed point, WORD_BITS total, FRAC_BITS fraction bits
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // multiplier operand holds a bound or the lerp weight 1.0 - t
  localparam int OPW   = WORD_BITS + 1;
  // full product of two operands
  localparam int PRODW = 2 * OPW;
  // sum of two rounded products
  localparam int SUMW  = PRODW + 1;
  // non-product results, wide enough to negate a bound
  localparam int DIRW  = WORD_BITS + 2;

  typedef logic signed [WORD_BITS-1:0] bound_t;
  typedef logic signed [OPW-1:0]       oper_t;
  typedef logic signed [PRODW-1:0]     prod_t;
  typedef logic signed [SUMW-1:0]      sum_t;
  typedef logic signed [DIRW-1:0]      dir_t;

  // operation codes
  typedef enum logic [2:0] {
    CMD_MUL       = 3'd0,
    CMD_SCALE     = 3'd1,
    CMD_SQUARE    = 3'd2,
    CMD_ABS       = 3'd3,
    CMD_MAX       = 3'd4,
    CMD_MIN       = 3'd5,
    CMD_INTERSECT = 3'd6,
    CMD_LERP      = 3'd7
  } cmd_e;

  // which product, or combination of products, feeds a result bound
  typedef enum logic [2:0] {
    SRC_P0    = 3'd0,
    SRC_P1    = 3'd1,
    SRC_P2    = 3'd2,
    SRC_P3    = 3'd3,
    SRC_ZERO  = 3'd4,
    SRC_MIN01 = 3'd5,
    SRC_MAX01 = 3'd6,
    SRC_MAX23 = 3'd7
  } src_e;

  // input word
  typedef struct packed {
    logic [2:0] cmd;
    bound_t     x_lo;
    bound_t     x_hi;
    bound_t     y_lo;
    bound_t     y_hi;
    bound_t     real_arg;
  } in_word_t;

  // result word
  typedef struct packed {
    bound_t res_lo;
    bound_t res_hi;
    logic   empty_res;
    logic   above;
    logic   below;
    logic   overlap;
    logic   overflow;
  } res_word_t;

  // four products from the multiply stage
  typedef struct packed {
    prod_t p0;
    prod_t p1;
    prod_t p2;
    prod_t p3;
  } prod_set_t;

  // product routing decided from the sign cases
  typedef struct packed {
    src_e lo_src;
    src_e hi_src;
    logic lerp;
  } sel_t;

  // per-word context that rides along the pipeline
  typedef struct packed {
    logic use_prod;
    logic empty;
    logic above;
    logic below;
    dir_t dir_lo;
    dir_t dir_hi;
  } ctx_t;

  // rounded products, two per bound (second one used by lerp only)
  typedef struct packed {
    prod_t lo_a;
    prod_t lo_b;
    prod_t hi_a;
    prod_t hi_b;
  } rnd_set_t;

endpackage

`default_nettype wire

>>> sv/iau_prod_stage.sv
// First pipeline stage: operand selection, four signed multipliers,
// sign-case routing, comparison flags and the non-product results.
// Depends on iau_pkg.
`default_nettype none

module iau_prod_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_vld,
  input  iau_pkg::in_word_t     in_word,
  output logic                  out_vld,
  output iau_pkg::prod_set_t    prod,
  output iau_pkg::sel_t         sel,
  output iau_pkg::ctx_t         ctx
);
  import iau_pkg::*;

  localparam oper_t ONE_OP = oper_t'(1) <<< FRAC_BITS;
  localparam dir_t  ONE_D  = dir_t'(1) <<< FRAC_BITS;

  cmd_e      cmd;
  bound_t    xa, xb, ya, yb, r;
  oper_t     oxa, oxb, oya, oyb, orr, ow;
  oper_t     a0, b0, a1, b1, a2, b2, a3, b3;
  logic      xa_nn, xb_np, ya_nn, yb_np, r_pos;
  logic      above, below;
  dir_t      dxa, dxb, neg_xa, neg_xb;
  prod_set_t prod_next;
  sel_t      sel_next;
  ctx_t      ctx_next;

  function automatic oper_t oext(input bound_t v);
    oext = {v[WORD_BITS-1], v};
  endfunction

  function automatic dir_t dext(input bound_t v);
    dext = {{(DIRW-WORD_BITS){v[WORD_BITS-1]}}, v};
  endfunction

  assign cmd = cmd_e'(in_word.cmd);
  assign xa  = in_word.x_lo;
  assign xb  = in_word.x_hi;
  assign ya  = in_word.y_lo;
  assign yb  = in_word.y_hi;
  assign r   = in_word.real_arg;

  // operand forms and sign cases
  assign oxa = oext(xa);
  assign oxb = oext(xb);
  assign oya = oext(ya);
  assign oyb = oext(yb);
  assign orr = oext(r);
  assign ow  = ONE_OP - orr;

  assign xa_nn = !xa[WORD_BITS-1];
  assign xb_np = xb[WORD_BITS-1] || (xb == '0);
  assign ya_nn = !ya[WORD_BITS-1];
  assign yb_np = yb[WORD_BITS-1] || (yb == '0);
  assign r_pos = !r[WORD_BITS-1] && (r != '0);

  assign above = xa > yb;
  assign below = xb < ya;

  assign dxa    = dext(xa);
  assign dxb    = dext(xb);
  assign neg_xa = -dxa;
  assign neg_xb = -dxb;

  // multiplier operands per operation
  always_comb begin
    a0 = '0; b0 = '0; a1 = '0; b1 = '0;
    a2 = '0; b2 = '0; a3 = '0; b3 = '0;
    case (cmd)
      CMD_MUL: begin
        a0 = oxa; b0 = oyb;
        a1 = oxb; b1 = oya;
        a2 = oxa; b2 = oya;
        a3 = oxb; b3 = oyb;
      end
      CMD_SCALE: begin
        a0 = orr; b0 = oxa;
        a1 = orr; b1 = oxb;
      end
      CMD_SQUARE: begin
        a0 = oxa; b0 = oxa;
        a1 = oxb; b1 = oxb;
      end
      CMD_LERP: begin
        a0 = ow;  b0 = oxa;
        a1 = orr; b1 = oya;
        a2 = ow;  b2 = oxb;
        a3 = orr; b3 = oyb;
      end
      default: begin
      end
    endcase
  end

  // four products in parallel
  assign prod_next.p0 = a0 * b0;
  assign prod_next.p1 = a1 * b1;
  assign prod_next.p2 = a2 * b2;
  assign prod_next.p3 = a3 * b3;

  // product routing from the sign cases
  always_comb begin
    sel_next.lo_src = SRC_ZERO;
    sel_next.hi_src = SRC_ZERO;
    sel_next.lerp   = 1'b0;
    case (cmd)
      CMD_MUL: begin
        // p0 = xa*yb, p1 = xb*ya, p2 = xa*ya, p3 = xb*yb
        if (xa_nn) begin
          if (ya_nn) begin
            sel_next.lo_src = SRC_P2; sel_next.hi_src = SRC_P3;
          end else if (yb_np) begin
            sel_next.lo_src = SRC_P1; sel_next.hi_src = SRC_P0;
          end else begin
            sel_next.lo_src = SRC_P1; sel_next.hi_src = SRC_P3;
          end
        end else if (xb_np) begin
          if (ya_nn) begin
            sel_next.lo_src = SRC_P0; sel_next.hi_src = SRC_P1;
          end else if (yb_np) begin
            sel_next.lo_src = SRC_P3; sel_next.hi_src = SRC_P2;
          end else begin
            sel_next.lo_src = SRC_P0; sel_next.hi_src = SRC_P2;
          end
        end else begin
          if (ya_nn) begin
            sel_next.lo_src = SRC_P0; sel_next.hi_src = SRC_P3;
          end else if (yb_np) begin
            sel_next.lo_src = SRC_P1; sel_next.hi_src = SRC_P2;
          end else begin
            sel_next.lo_src = SRC_MIN01; sel_next.hi_src = SRC_MAX23;
          end
        end
      end
      CMD_SCALE: begin
        // bounds swap unless the factor is positive
        if (r_pos) begin
          sel_next.lo_src = SRC_P0; sel_next.hi_src = SRC_P1;
        end else begin
          sel_next.lo_src = SRC_P1; sel_next.hi_src = SRC_P0;
        end
      end
      CMD_SQUARE: begin
        if (xa_nn) begin
          sel_next.lo_src = SRC_P0; sel_next.hi_src = SRC_P1;
        end else if (xb_np) begin
          sel_next.lo_src = SRC_P1; sel_next.hi_src = SRC_P0;
        end else begin
          sel_next.lo_src = SRC_ZERO; sel_next.hi_src = SRC_MAX01;
        end
      end
      CMD_LERP: begin
        sel_next.lo_src = SRC_P0;
        sel_next.hi_src = SRC_P2;
        sel_next.lerp   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // results that need no multiplier
  always_comb begin
    ctx_next.use_prod = 1'b0;
    ctx_next.empty    = 1'b0;
    ctx_next.above    = above;
    ctx_next.below    = below;
    ctx_next.dir_lo   = '0;
    ctx_next.dir_hi   = '0;
    case (cmd)
      CMD_MUL, CMD_SCALE, CMD_SQUARE, CMD_LERP: begin
        ctx_next.use_prod = 1'b1;
      end
      CMD_ABS: begin
        if (xa_nn) begin
          ctx_next.dir_lo = dxa;
          ctx_next.dir_hi = dxb;
        end else if (xb_np) begin
          ctx_next.dir_lo = neg_xb;
          ctx_next.dir_hi = neg_xa;
        end else begin
          ctx_next.dir_hi = (neg_xa > dxb) ? neg_xa : dxb;
        end
      end
      CMD_MAX: begin
        ctx_next.dir_lo = dext((xa > ya) ? xa : ya);
        ctx_next.dir_hi = dext((xb > yb) ? xb : yb);
      end
      CMD_MIN: begin
        ctx_next.dir_lo = dext((xa < ya) ? xa : ya);
        ctx_next.dir_hi = dext((xb < yb) ? xb : yb);
      end
      CMD_INTERSECT: begin
        // disjoint intervals give the empty marker 1.0 .. -1.0
        if (above || below) begin
          ctx_next.empty  = 1'b1;
          ctx_next.dir_lo = ONE_D;
          ctx_next.dir_hi = -ONE_D;
        end else begin
          ctx_next.dir_lo = dext((xa > ya) ? xa : ya);
          ctx_next.dir_hi = dext((xb < yb) ? xb : yb);
        end
      end
      default: begin
      end
    endcase
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    prod <= prod_next;
    sel  <= sel_next;
    ctx  <= ctx_next;
  end

endmodule

`default_nettype wire

>>> sv/iau_round_stage.sv
// Second pipeline stage: picks the product for each bound (with the
// min/max of the straddling cases) and rounds products half up.
// Depends on iau_pkg.
`default_nettype none

module iau_round_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_vld,
  input  iau_pkg::prod_set_t    prod,
  input  iau_pkg::sel_t         sel,
  input  iau_pkg::ctx_t         in_ctx,
  output logic                  out_vld,
  output iau_pkg::rnd_set_t     rnd,
  output iau_pkg::ctx_t         ctx
);
  import iau_pkg::*;

  localparam prod_t RND_HALF = (prod_t'(1) <<< FRAC_BITS) >>> 1;

  logic     lt01, lt23;
  prod_t    lo_pick, hi_pick, lo_b, hi_b;
  rnd_set_t rnd_next;

  // rounding is monotone, so min/max of raw products picks the same term
  function automatic prod_t pick(input src_e src, input prod_set_t p,
                                 input logic l01, input logic l23);
    case (src)
      SRC_P0:    pick = p.p0;
      SRC_P1:    pick = p.p1;
      SRC_P2:    pick = p.p2;
      SRC_P3:    pick = p.p3;
      SRC_MIN01: pick = l01 ? p.p0 : p.p1;
      SRC_MAX01: pick = l01 ? p.p1 : p.p0;
      SRC_MAX23: pick = l23 ? p.p3 : p.p2;
      default:   pick = '0;
    endcase
  endfunction

  // add half an lsb, then arithmetic shift (floor)
  function automatic prod_t round_q(input prod_t v);
    prod_t t;
    t = v + RND_HALF;
    round_q = t >>> FRAC_BITS;
  endfunction

  assign lt01 = prod.p0 < prod.p1;
  assign lt23 = prod.p2 < prod.p3;

  assign lo_pick = pick(sel.lo_src, prod, lt01, lt23);
  assign hi_pick = pick(sel.hi_src, prod, lt01, lt23);
  assign lo_b    = sel.lerp ? prod.p1 : '0;
  assign hi_b    = sel.lerp ? prod.p3 : '0;

  assign rnd_next.lo_a = round_q(lo_pick);
  assign rnd_next.lo_b = round_q(lo_b);
  assign rnd_next.hi_a = round_q(hi_pick);
  assign rnd_next.hi_b = round_q(hi_b);

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    rnd <= rnd_next;
    ctx <= in_ctx;
  end

endmodule

`default_nettype wire

>>> sv/iau_sat_stage.sv
// Last pipeline stage: adds the lerp terms, merges the non-product
// results, saturates both bounds and registers the result word.
// Depends on iau_pkg.
`default_nettype none

module iau_sat_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_vld,
  input  iau_pkg::rnd_set_t     rnd,
  input  iau_pkg::ctx_t         ctx,
  output logic                  out_vld,
  output iau_pkg::res_word_t    res
);
  import iau_pkg::*;

  localparam sum_t SAT_MAX = {{(SUMW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam sum_t SAT_MIN = ~SAT_MAX;

  typedef struct packed {
    logic   ovf;
    bound_t val;
  } sat_res_t;

  sum_t      lo_sum, hi_sum;
  sat_res_t  lo_sat, hi_sat;
  res_word_t res_next;

  function automatic sum_t pext(input prod_t v);
    pext = {v[PRODW-1], v};
  endfunction

  function automatic sum_t dext(input dir_t v);
    dext = {{(SUMW-DIRW){v[DIRW-1]}}, v};
  endfunction

  // clamp to the bound range
  function automatic sat_res_t sat(input sum_t v);
    if (v > SAT_MAX) begin
      sat.ovf = 1'b1;
      sat.val = SAT_MAX[WORD_BITS-1:0];
    end else if (v < SAT_MIN) begin
      sat.ovf = 1'b1;
      sat.val = SAT_MIN[WORD_BITS-1:0];
    end else begin
      sat.ovf = 1'b0;
      sat.val = v[WORD_BITS-1:0];
    end
  endfunction

  // bound values before clamping
  assign lo_sum = ctx.use_prod ? (pext(rnd.lo_a) + pext(rnd.lo_b)) : dext(ctx.dir_lo);
  assign hi_sum = ctx.use_prod ? (pext(rnd.hi_a) + pext(rnd.hi_b)) : dext(ctx.dir_hi);

  assign lo_sat = sat(lo_sum);
  assign hi_sat = sat(hi_sum);

  // result word
  assign res_next.res_lo    = lo_sat.val;
  assign res_next.res_hi    = hi_sat.val;
  assign res_next.empty_res = ctx.empty;
  assign res_next.above     = ctx.above;
  assign res_next.below     = ctx.below;
  assign res_next.overlap   = !(ctx.above || ctx.below);
  assign res_next.overflow  = lo_sat.ovf || hi_sat.ovf;

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

`default_nettype wire

>>> sv/interval_arithmetic_unit.sv
// Interval arithmetic unit on signed fixed-point bounds.
//
// Usage:
//   A word is taken on req at a rising edge where start is high and busy is
//   low. busy never rises: the pipeline takes one word every cycle, with no
//   state carried from one word to the next.
//   Each word yields exactly one result word on res, shown for one cycle
//   while done is high; the receiver takes it at the edge ending that cycle
//   and cannot stall, so nothing waits on the output side.
// Result path:
//   an accepted word passes the input register, product register, rounding
//   register and result register in that order, and done is registered with
//   the result word. Results leave in the order words came in.
// Throughput:
//   one word per cycle, as no stage ever stalls; the product stage holds
//   four multipliers that work in parallel.
// Reset:
//   synchronous rst clears the valid bits of all stages, so no done strobe
//   follows reset until a new word is taken.
// Depends on iau_pkg, iau_prod_stage, iau_round_stage, iau_sat_stage.
`default_nettype none

module interval_arithmetic_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  iau_pkg::in_word_t     req,
  output logic                  done,
  output iau_pkg::res_word_t    res
);
  import iau_pkg::*;

  logic      in_vld;
  in_word_t  in_q;
  logic      p_vld;
  prod_set_t p_prod;
  sel_t      p_sel;
  ctx_t      p_ctx;
  logic      r_vld;
  rnd_set_t  r_rnd;
  ctx_t      r_ctx;

  // always ready for a word
  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_q <= req;
  end

  // multiply stage
  iau_prod_stage u_prod (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (in_vld),
    .in_word (in_q),
    .out_vld (p_vld),
    .prod    (p_prod),
    .sel     (p_sel),
    .ctx     (p_ctx)
  );

  // select and round stage
  iau_round_stage u_round (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (p_vld),
    .prod    (p_prod),
    .sel     (p_sel),
    .in_ctx  (p_ctx),
    .out_vld (r_vld),
    .rnd     (r_rnd),
    .ctx     (r_ctx)
  );

  // sum, saturate and result register
  iau_sat_stage u_sat (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (r_vld),
    .rnd     (r_rnd),
    .ctx     (r_ctx),
    .out_vld (done),
    .res     (res)
  );

endmodule

`default_nettype wire

>>> sv/iau_checker.sv
// Port-level checks for the interval arithmetic unit, bound to the top.
// Depends on iau_pkg and interval_arithmetic_unit.
`default_nettype none

module iau_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  iau_pkg::in_word_t     req,
  input  logic                  done,
  input  iau_pkg::res_word_t    res
);
  import iau_pkg::*;

  logic take;

  assign take = start && !busy;

  // every accepted word gives a result word after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    take |-> ##4 done)
    else $error("accepted word produced no result word");

  // no result word without an accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !take |-> ##4 !done)
    else $error("result word without an accepted word");

  // overlap is exactly the absence of above and below
  a_flags_consistent: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.overlap == !(res.above || res.below)))
    else $error("comparison flags disagree");

  // an empty intersection only arises from disjoint intervals
  a_empty_disjoint: assert property (@(posedge clk) disable iff (rst)
    (done && res.empty_res) |-> !res.overlap)
    else $error("empty result with overlapping intervals");

  // the empty-marker word comes from the intersect command
  a_empty_cmd: assert property (@(posedge clk) disable iff (rst)
    (take && (req.cmd != CMD_INTERSECT)) |-> ##4 !res.empty_res)
    else $error("empty flag set for a command other than intersect");

endmodule

bind interval_arithmetic_unit iau_checker u_iau_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .req   (req),
  .done  (done),
  .res   (res)
);

`default_nettype wire

>>> tb/interval_arithmetic_unit_tb.sv
// Self-checking testbench for the interval arithmetic unit: directed and random words.
// Predicts each result word in place and compares it with the done strobe output.
// Depends on iau_pkg and interval_arithmetic_unit.
`timescale 1ns / 1ps

module interval_arithmetic_unit_tb;
  import iau_pkg::*;

  localparam longint ONE_FX    = longint'(1) <<< FRAC_BITS;
  localparam longint HALF_FX   = ONE_FX >>> 1;
  localparam longint BOUND_MAX = (longint'(1) <<< (WORD_BITS - 1)) - 1;
  localparam longint BOUND_MIN = -BOUND_MAX - 1;
  localparam bound_t B_MAX     = bound_t'(BOUND_MAX);
  localparam bound_t B_MIN     = bound_t'(BOUND_MIN);

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_word_t  req;
  logic      done;
  res_word_t res;

  res_word_t pending_results[$];
  res_word_t want_word;
  int        error_count;
  int        sender_idle_pct;

  interval_arithmetic_unit i_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .res   (res)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // whole number of units as a Q16.16 bound
  function automatic bound_t q(int units);
    return bound_t'(units) <<< FRAC_BITS;
  endfunction

  // rounded fixed-point product, half up
  function automatic longint round_mul(longint a, longint b);
    return (a * b + HALF_FX) >>> FRAC_BITS;
  endfunction

  function automatic bound_t clamp_bound(longint v);
    if (v > BOUND_MAX) return B_MAX;
    if (v < BOUND_MIN) return B_MIN;
    return bound_t'(v);
  endfunction

  // expected result word for one input word
  function automatic res_word_t interval_result(in_word_t w);
    longint    xa, xb, ya, yb, r, wt, lo, hi, pa, pb;
    res_word_t o;
    xa = longint'($signed(w.x_lo));
    xb = longint'($signed(w.x_hi));
    ya = longint'($signed(w.y_lo));
    yb = longint'($signed(w.y_hi));
    r  = longint'($signed(w.real_arg));
    lo = 0;
    hi = 0;
    o = '0;
    o.above   = xa > yb;
    o.below   = xb < ya;
    o.overlap = !(o.above || o.below);
    case (cmd_e'(w.cmd))
      CMD_MUL: begin
        // sign cases of both intervals, bounds taken as given
        if (xa >= 0) begin
          if (ya >= 0) begin
            lo = round_mul(xa, ya); hi = round_mul(xb, yb);
          end else if (yb <= 0) begin
            lo = round_mul(xb, ya); hi = round_mul(xa, yb);
          end else begin
            lo = round_mul(xb, ya); hi = round_mul(xb, yb);
          end
        end else if (xb <= 0) begin
          if (ya >= 0) begin
            lo = round_mul(xa, yb); hi = round_mul(xb, ya);
          end else if (yb <= 0) begin
            lo = round_mul(xb, yb); hi = round_mul(xa, ya);
          end else begin
            lo = round_mul(xa, yb); hi = round_mul(xa, ya);
          end
        end else begin
          if (ya >= 0) begin
            lo = round_mul(xa, yb); hi = round_mul(xb, yb);
          end else if (yb <= 0) begin
            lo = round_mul(xb, ya); hi = round_mul(xa, ya);
          end else begin
            pa = round_mul(xa, yb);
            pb = round_mul(xb, ya);
            lo = (pa < pb) ? pa : pb;
            pa = round_mul(xa, ya);
            pb = round_mul(xb, yb);
            hi = (pa > pb) ? pa : pb;
          end
        end
      end
      CMD_SCALE: begin
        if (r > 0) begin
          lo = round_mul(r, xa); hi = round_mul(r, xb);
        end else begin
          lo = round_mul(r, xb); hi = round_mul(r, xa);
        end
      end
      CMD_SQUARE: begin
        if (xa >= 0) begin
          lo = round_mul(xa, xa); hi = round_mul(xb, xb);
        end else if (xb <= 0) begin
          lo = round_mul(xb, xb); hi = round_mul(xa, xa);
        end else begin
          pa = round_mul(xa, xa);
          pb = round_mul(xb, xb);
          lo = 0;
          hi = (pa > pb) ? pa : pb;
        end
      end
      CMD_ABS: begin
        if (xa >= 0) begin
          lo = xa; hi = xb;
        end else if (xb <= 0) begin
          lo = -xb; hi = -xa;
        end else begin
          lo = 0;
          hi = (-xa > xb) ? -xa : xb;
        end
      end
      CMD_MAX: begin
        lo = (xa > ya) ? xa : ya;
        hi = (xb > yb) ? xb : yb;
      end
      CMD_MIN: begin
        lo = (xa < ya) ? xa : ya;
        hi = (xb < yb) ? xb : yb;
      end
      CMD_INTERSECT: begin
        if (o.above || o.below) begin
          o.empty_res = 1'b1;
          lo = ONE_FX;
          hi = -ONE_FX;
        end else begin
          lo = (xa > ya) ? xa : ya;
          hi = (xb < yb) ? xb : yb;
        end
      end
      default: begin
        // lerp: each product rounded on its own, then summed exactly
        wt = ONE_FX - r;
        lo = round_mul(wt, xa) + round_mul(r, ya);
        hi = round_mul(wt, xb) + round_mul(r, yb);
      end
    endcase
    o.overflow = (lo > BOUND_MAX) || (lo < BOUND_MIN) || (hi > BOUND_MAX) || (hi < BOUND_MIN);
    o.res_lo = clamp_bound(lo);
    o.res_hi = clamp_bound(hi);
    return o;
  endfunction

  function automatic in_word_t make_word(cmd_e c, bound_t xl, bound_t xh, bound_t yl,
                                         bound_t yh, bound_t r);
    in_word_t w;
    w.cmd      = c;
    w.x_lo     = xl;
    w.x_hi     = xh;
    w.y_lo     = yl;
    w.y_hi     = yh;
    w.real_arg = r;
    return w;
  endfunction

  function automatic bound_t pick_extreme();
    case ($urandom_range(0, 6))
      0: return B_MIN;
      1: return B_MAX;
      2: return '0;
      3: return bound_t'(1);
      4: return bound_t'(-1);
      5: return q(1);
      default: return q(-1);
    endcase
  endfunction

  // bound drawn from a mix of magnitudes
  function automatic bound_t rand_bound();
    case ($urandom_range(0, 9))
      0, 1, 2: return bound_t'($urandom);
      3, 4, 5: return bound_t'(int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
      6, 7:    return bound_t'(int'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000);
      8:       return pick_extreme();
      default: return bound_t'(int'($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  function automatic bound_t rand_real();
    case ($urandom_range(0, 4))
      0:       return bound_t'($urandom);
      1:       return bound_t'(int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000);
      2:       return pick_extreme();
      default: return bound_t'($urandom_range(0, 32'h0001_0000));
    endcase
  endfunction

  // random word: mostly well-ordered intervals, some reversed ones
  function automatic in_word_t rand_word();
    bound_t a, b, c, d, t;
    a = rand_bound();
    b = rand_bound();
    if ($urandom_range(0, 99) < 85 && a > b) begin
      t = a; a = b; b = t;
    end
    if ($urandom_range(0, 99) < 30) begin
      // y placed near x so overlap and touching cases come up often
      c = a + bound_t'(int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000);
      d = b + bound_t'(int'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000);
    end else begin
      c = rand_bound();
      d = rand_bound();
    end
    if ($urandom_range(0, 99) < 85 && c > d) begin
      t = c; c = d; d = t;
    end
    return make_word(cmd_e'($urandom_range(0, 7)), a, b, c, d, rand_real());
  endfunction

  // send one word, holding start until the unit takes it
  task automatic send_word(in_word_t w);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off until every predicted result has come out
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic test_products();
    send_word(make_word(CMD_MUL, q(1), q(2), q(3), q(4), '0));
    send_word(make_word(CMD_MUL, q(-2), q(3), q(-5), q(4), '0));
    send_word(make_word(CMD_MUL, B_MIN, B_MAX, B_MIN, B_MAX, '0));
    send_word(make_word(CMD_SCALE, q(1), q(2), '0, '0, bound_t'(32'shFFFE_8000)));
    send_word(make_word(CMD_SCALE, q(-3), q(5), '0, '0, '0));
    // half an lsb rounds up on both signs
    send_word(make_word(CMD_SCALE, bound_t'(1), bound_t'(3), '0, '0, q(1) >>> 1));
    send_word(make_word(CMD_SCALE, bound_t'(-3), bound_t'(-1), '0, '0, q(1) >>> 1));
    send_word(make_word(CMD_SQUARE, q(-3), q(2), '0, '0, '0));
    send_word(make_word(CMD_SQUARE, B_MIN, B_MIN, '0, '0, '0));
  endtask

  task automatic test_bound_ops();
    send_word(make_word(CMD_ABS, B_MIN, bound_t'(-1), '0, '0, '0));
    send_word(make_word(CMD_ABS, q(-7), q(4), '0, '0, '0));
    send_word(make_word(CMD_MAX, q(-1), q(5), q(2), q(3), '0));
    send_word(make_word(CMD_MIN, q(-1), q(5), q(2), q(3), '0));
  endtask

  task automatic test_intersect();
    send_word(make_word(CMD_INTERSECT, q(-1), q(5), q(2), q(8), '0));
    send_word(make_word(CMD_INTERSECT, q(6), q(9), q(1), q(5), '0));
    send_word(make_word(CMD_INTERSECT, q(1), q(2), q(3), q(4), '0));
    // touching bounds still overlap
    send_word(make_word(CMD_INTERSECT, q(1), q(3), q(3), q(4), '0));
  endtask

  task automatic test_lerp();
    send_word(make_word(CMD_LERP, q(0), q(2), q(4), q(6), q(1) >>> 1));
    send_word(make_word(CMD_LERP, B_MAX, B_MIN, B_MIN, B_MAX, B_MIN));
    send_word(make_word(CMD_LERP, B_MIN, B_MAX, B_MAX, B_MIN, B_MAX));
  endtask

  // reversed bounds and all-zero / all-one bit patterns
  task automatic test_odd_intervals();
    send_word(make_word(CMD_MUL, q(3), q(-2), q(-1), q(-4), '0));
    send_word(make_word(CMD_MUL, '0, '0, '0, '0, '0));
    send_word(make_word(CMD_LERP, '1, '1, '1, '1, '1));
  endtask

  task automatic run_random_words(int count);
    repeat (count) send_word(rand_word());
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // record every accepted word and check every result word
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, res);
          error_count++;
        end else begin
          want_word = pending_results.pop_front();
          check_field("res_lo", $signed(want_word.res_lo), $signed(res.res_lo));
          check_field("res_hi", $signed(want_word.res_hi), $signed(res.res_hi));
          check_field("empty_res", want_word.empty_res, res.empty_res);
          check_field("above", want_word.above, res.above);
          check_field("below", want_word.below, res.below);
          check_field("overlap", want_word.overlap, res.overlap);
          check_field("overflow", want_word.overflow, res.overflow);
        end
      end
      if (start && !busy) pending_results.push_back(interval_result(req));
    end
  end

  // stimulus
  initial begin
    error_count     = 0;
    sender_idle_pct = 13;
    rst   = 1'b1;
    start = 1'b0;
    req   = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_products();
    test_bound_ops();
    test_intersect();
    test_lerp();
    test_odd_intervals();
    wait_for_results();
    run_random_words(450);
    wait_for_results();
    sender_idle_pct = 87;
    run_random_words(450);
    wait_for_results();
    sender_idle_pct = 0;
    run_random_words(450);
    wait_for_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
